### design/swfe_pkg.sv
// Shared types and constants for the sync word frame extractor.
`default_nettype none

package swfe_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_ACCEPT  = 2'd1;
    localparam kind_t KIND_REJECT  = 2'd2;

    // Register map, one 32-bit register every four bytes.
    localparam int          ADDR_W    = 3;
    localparam logic        REG_FRAME_LEN = 1'b0;
    localparam logic        REG_SYNC      = 1'b1;

    localparam logic [31:0] FRAME_LEN_RESET = 32'd4147200;
    localparam logic [31:0] SYNC_RESET      = 32'h12345678;

endpackage

`default_nettype wire

### design/swfe_core.sv
// Framing state machine: sync hunt, payload streaming and next-header check.
`default_nettype none

module swfe_core #(
    parameter int LEN_BITS = 23
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            rx_byte,
    input  wire logic [LEN_BITS-1:0]   frame_len,
    input  wire logic [31:0]           sync_pattern,
    output logic                       res_valid,
    output swfe_pkg::kind_t            res_kind,
    output logic [7:0]                 res_data,
    output logic [LEN_BITS-1:0]        res_index,
    output logic [31:0]                res_ok,
    output logic [31:0]                res_bad
);
    import swfe_pkg::*;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    logic [1:0]          phase_reg,  phase_next;
    logic [31:0]         window_reg, window_next;
    logic [LEN_BITS-1:0] count_reg,  count_next;
    logic [1:0]          check_reg,  check_next;
    logic [31:0]         ok_reg,     ok_next;
    logic [31:0]         bad_reg,    bad_next;

    logic [LEN_BITS-1:0] count_inc;
    logic [31:0]         shifted;
    logic [1:0]          start_phase;

    assign count_inc   = count_reg + 1'b1;
    assign shifted     = {window_reg[23:0], rx_byte};
    assign start_phase = (frame_len == '0) ? PH_CHECK : PH_PAYLOAD;

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        check_next  = check_reg;
        ok_next     = ok_reg;
        bad_next    = bad_reg;
        res_valid   = 1'b0;
        res_kind    = KIND_PAYLOAD;
        res_data    = 8'd0;
        res_index   = '0;

        case (phase_reg)
            PH_PAYLOAD:
            begin
                res_valid  = 1'b1;
                res_data   = rx_byte;
                res_index  = count_reg;
                count_next = count_inc;
                if (count_inc >= frame_len)
                begin
                    phase_next = PH_CHECK;
                    check_next = 2'd0;
                end
            end
            PH_CHECK:
            begin
                window_next = shifted;
                if (check_reg != 2'd3)
                begin
                    check_next = check_reg + 2'd1;
                end
                else if (shifted == sync_pattern)
                begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_ACCEPT;
                    ok_next    = ok_reg + 32'd1;
                    count_next = '0;
                    check_next = 2'd0;
                    phase_next = start_phase;
                end
                else
                begin
                    // The checked bytes stay in the window, so hunting resumes on them.
                    res_valid  = 1'b1;
                    res_kind   = KIND_REJECT;
                    bad_next   = bad_reg + 32'd1;
                    check_next = 2'd3;
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                window_next = shifted;
                phase_next  = PH_HUNT;
                if (check_reg != 2'd3)
                begin
                    check_next = check_reg + 2'd1;
                end
                else if (shifted == sync_pattern)
                begin
                    count_next = '0;
                    check_next = 2'd0;
                    phase_next = start_phase;
                end
            end
        endcase

        res_valid = res_valid & accept;
        res_ok    = ok_next;
        res_bad   = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            count_reg  <= '0;
            check_reg  <= 2'd0;
            ok_reg     <= '0;
            bad_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            check_reg  <= check_next;
            ok_reg     <= ok_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

`default_nettype wire

### design/swfe_skid.sv
// Output register with a skid stage so the input side keeps flowing under stall.
`default_nettype none

module swfe_skid #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DATA_W-1:0]      out_data
);
    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] main_data_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              main_free;

    // The main register can load when it is empty or its word leaves this cycle.
    assign main_free = !main_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

`default_nettype wire

### design/sync_word_frame_extractor_core.sv
// Top level of the sync word frame extractor: config registers, framer and output stage.
//
//  Channel   Direction  Handshake            Word
//  input     in         in_valid/in_stall    rx_byte
//  output    out        out_valid/out_stall  kind, payload_byte, byte_index,
//                                            frames_ok, frames_bad
//  config    in         APB psel/penable     frame_len at 0x0, sync_pattern at 0x4
//
// One received byte is taken every cycle while in_valid is high and in_stall is low.
// Framing state updates on the accepting edge; each result goes to an output register.
// A two-deep output stage holds results under stall; in_stall rises only once both are full.
// Reset clears all framing state and counters and loads the register reset values.
`default_nettype none

module sync_word_frame_extractor_core #(
    parameter int LEN_BITS = 23
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [swfe_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output swfe_pkg::kind_t                  kind,
    output logic [7:0]                       payload_byte,
    output logic [LEN_BITS-1:0]              byte_index,
    output logic [31:0]                      frames_ok,
    output logic [31:0]                      frames_bad
);
    import swfe_pkg::*;

    localparam int DATA_W = 2 + 8 + LEN_BITS + 64;

    logic [LEN_BITS-1:0] frame_len_reg;
    logic [31:0]         sync_reg;
    logic                reg_sel;
    logic                wr_en;
    logic                accept;

    logic                res_valid;
    kind_t               res_kind;
    logic [7:0]          res_data;
    logic [LEN_BITS-1:0] res_index;
    logic [31:0]         res_ok;
    logic [31:0]         res_bad;
    logic [DATA_W-1:0]   out_data;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= FRAME_LEN_RESET[LEN_BITS-1:0];
            sync_reg      <= SYNC_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_FRAME_LEN)
            begin
                frame_len_reg <= pwdata[LEN_BITS-1:0];
            end
            else
            begin
                sync_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_SYNC)
        begin
            prdata = sync_reg;
        end
        else
        begin
            prdata[LEN_BITS-1:0] = frame_len_reg;
        end
    end

    assign accept = in_valid && !in_stall;

    swfe_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .frame_len    (frame_len_reg),
        .sync_pattern (sync_reg),
        .res_valid    (res_valid),
        .res_kind     (res_kind),
        .res_data     (res_data),
        .res_index    (res_index),
        .res_ok       (res_ok),
        .res_bad      (res_bad)
    );

    swfe_skid #(
        .DATA_W (DATA_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data ({res_kind, res_data, res_index, res_ok, res_bad}),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign {kind, payload_byte, byte_index, frames_ok, frames_bad} = out_data;

endmodule

`default_nettype wire
